@@ rtl/ftbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbc_pkg
// Shared constants, types and round logic for the two-branch Feistel cipher.
// ----------------------------------------------------------------------------
package ftbc_pkg;

    localparam int ROUNDS    = 2;
    localparam int IDX_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int BLOCK_W   = 64;
    localparam int HALF_W    = 32;
    localparam int KEY_W     = 64;
    localparam int ROT_F_L   = 7;
    localparam int ROT_K     = 9;

    localparam logic [KEY_W-1:0] KEY_RESET = 64'hF7B1_CAF0_D1EB_6C3B;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // One pipeline slot handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               op;
        logic [BLOCK_W-1:0] block;
    } stage_t;

    function automatic logic [HALF_W-1:0] round_fn(
        input logic [HALF_W-1:0] l,
        input logic [HALF_W-1:0] k
    );
        logic [HALF_W-1:0] l_ror;
        logic [HALF_W-1:0] k_rol;
        l_ror = {l[ROT_F_L-1:0], l[HALF_W-1:ROT_F_L]};
        k_rol = {k[HALF_W-ROT_K-1:0], k[HALF_W-1:HALF_W-ROT_K]};
        return l_ror ^ (k_rol | l);
    endfunction

endpackage

@@ rtl/feistel_two_branch_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_two_branch_cipher
// 64-bit two-branch Feistel cipher, one round cell per round in a chain.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                          Handshake
//  s_*      in   tdata: block_in, tuser: op       s_tvalid / s_tready
//  m_*      out  tdata: block_out                 m_tvalid / m_tready
//  cfg_*    in   cfg_data: cipher_key             cfg_valid / cfg_ready
//
//  One block per cycle sustained while the output is not stalled; one register per round cell.
//  The last cell's register is the output register.
//  A stalled output freezes the whole chain; s_tready drops only then.
//  Reset clears the slot valid bits and loads the default key.
// ----------------------------------------------------------------------------
module feistel_two_branch_cipher
    import ftbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BLOCK_W-1:0] s_tdata,   // [63:0] block_in
    input  logic               s_tuser,   // [0] op
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BLOCK_W-1:0] m_tdata,   // [63:0] block_out
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [KEY_W-1:0]   cfg_data
);

    logic [KEY_W-1:0] key_reg;
    logic             chain_en;
    stage_t           pipe [ROUNDS+1];

    assign chain_en  = !pipe[ROUNDS].valid || m_tready;
    assign s_tready  = chain_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    assign pipe[0].valid = s_tvalid;
    assign pipe[0].op    = s_tuser;
    assign pipe[0].block = s_tdata;

    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_cell
        ftbc_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (chain_en),
            .round_num (IDX_W'(g)),
            .is_last   (g == ROUNDS - 1),
            .key       (key_reg),
            .slot_in   (pipe[g]),
            .slot_out  (pipe[g+1])
        );
    end

    assign m_tvalid = pipe[ROUNDS].valid;
    assign m_tdata  = pipe[ROUNDS].block;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> pipe[1].valid)
        else $error("accepted request lost at first cell");

    a_stall_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        !chain_en |=> (m_tvalid && $stable(m_tdata)))
        else $error("chain advanced while frozen");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (key_reg == $past(cfg_data)))
        else $error("key write not taken");

endmodule

@@ rtl/ftbc_round_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftbc_round_cell
// One Feistel round with its output register; passes the slot to the next cell.
// ----------------------------------------------------------------------------
module ftbc_round_cell
    import ftbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [IDX_W-1:0]  round_num,
    input  logic              is_last,
    input  logic [KEY_W-1:0]  key,
    input  stage_t            slot_in,
    output stage_t            slot_out
);

    logic                 valid_reg;
    logic                 op_reg;
    logic [BLOCK_W-1:0]   block_reg;

    logic [IDX_W-1:0]     key_idx;
    logic [5:0]           rot_amt;
    logic [2*KEY_W-1:0]   key_rot;
    logic [HALF_W-1:0]    round_key;
    logic [HALF_W-1:0]    l_in;
    logic [HALF_W-1:0]    r_in;
    logic [HALF_W-1:0]    r_mix;
    logic [BLOCK_W-1:0]   block_next;

    // decrypt walks the key schedule backwards
    assign key_idx   = (slot_in.op == OP_DECRYPT) ? (IDX_W'(ROUNDS - 1) - round_num)
                                                  : round_num;
    assign rot_amt   = 6'({key_idx, 3'b000});
    assign key_rot   = {key, key} >> rot_amt;
    assign round_key = key_rot[HALF_W-1:0];

    assign l_in  = slot_in.block[HALF_W-1:0];
    assign r_in  = slot_in.block[BLOCK_W-1:HALF_W];
    assign r_mix = r_in ^ round_fn(l_in, round_key);

    // last round keeps the halves in place
    assign block_next = is_last ? {r_mix, l_in} : {l_in, r_mix};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= slot_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg    <= slot_in.op;
            block_reg <= block_next;
        end
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.op    = op_reg;
    assign slot_out.block = block_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-branch Feistel cipher stream block.
// Blocks go in on the slave stream with a random op and a random key setting.
// A behavioral copy of the cipher predicts every output block. Output blocks
// are checked in order. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module testbench;
    import ftbc_pkg::*;

    localparam int DRAIN_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BLOCK_W-1:0] s_tdata;   // [63:0] block_in
    logic               s_tuser;   // [0] op
    logic               m_tvalid;
    logic               m_tready;
    logic [BLOCK_W-1:0] m_tdata;   // [63:0] block_out
    logic               cfg_valid;
    logic               cfg_ready;
    logic [KEY_W-1:0]   cfg_data;

    logic [BLOCK_W-1:0] expected_blocks[$];
    logic [KEY_W-1:0]   key_shadow;
    logic [BLOCK_W-1:0] last_cipher;
    int unsigned        error_count;
    int unsigned        sender_idle_pct;
    int unsigned        receiver_stall_pct;

    feistel_two_branch_cipher uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Cipher prediction
    // ------------------------------------------------------------------
    // Round key: low word of the key rotated right by 8 bits per round
    function automatic logic [HALF_W-1:0] round_subkey(input logic [KEY_W-1:0] key,
                                                       input int unsigned rnd);
        logic [2*KEY_W-1:0] doubled;
        doubled = {key, key} >> ((8 * rnd) % 64);
        return doubled[HALF_W-1:0];
    endfunction

    function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] l,
                                                   input logic [HALF_W-1:0] k);
        logic [2*HALF_W-1:0] l_spun;
        logic [2*HALF_W-1:0] k_spun;
        l_spun = {l, l} >> 7;           // ror by 7
        k_spun = {k, k} >> (32 - 9);    // rol by 9
        return l_spun[HALF_W-1:0] ^ (k_spun[HALF_W-1:0] | l);
    endfunction

    function automatic logic [BLOCK_W-1:0] cipher_block(input logic op,
                                                        input logic [BLOCK_W-1:0] blk,
                                                        input logic [KEY_W-1:0] key);
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
        logic [HALF_W-1:0] next_left;
        int unsigned       rnd;
        left  = blk[HALF_W-1:0];
        right = blk[BLOCK_W-1:HALF_W];
        for (int n = 0; n < ROUNDS - 1; n++)
        begin
            rnd       = (op == OP_DECRYPT) ? ROUNDS - 1 - n : n;
            next_left = right ^ mix_half(left, round_subkey(key, rnd));
            right     = left;
            left      = next_left;
        end
        // last round keeps the halves in place
        rnd   = (op == OP_DECRYPT) ? 0 : ROUNDS - 1;
        right = right ^ mix_half(left, round_subkey(key, rnd));
        return {right, left};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                report_mismatch($sformatf("block_out %h with no request pending", m_tdata));
            end
            else
            begin
                if (m_tdata !== expected_blocks[0])
                begin
                    report_mismatch($sformatf("block_out got %h want %h",
                                              m_tdata, expected_blocks[0]));
                end
                void'(expected_blocks.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= blk;
        do
            @(posedge clk);
        while (!s_tready);
        expected_blocks.push_back(cipher_block(op, blk, key_shadow));
        last_cipher = cipher_block(op, blk, key_shadow);
        @(negedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // wait until every pending block is out, then let the pipe settle
    task automatic drain();
        int unsigned waited;
        waited = 0;
        stop_sending();
        while (expected_blocks.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_blocks.size() != 0)
        begin
            report_mismatch($sformatf("%0d blocks never came out", expected_blocks.size()));
            expected_blocks.delete();
        end
        repeat (ROUNDS + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] key);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        do
            @(posedge clk);
        while (!cfg_ready);
        key_shadow = key;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [BLOCK_W-1:0] rand_block();
        case ($urandom_range(9))
            0:       return {$urandom, 32'h0};
            1:       return {32'h0, $urandom};
            2:       return {$urandom, 32'hFFFF_FFFF};
            3:       return {32'hFFFF_FFFF, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_patterns();
        logic [BLOCK_W-1:0] patterns[8];
        patterns = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h1, 64'h8000_0000_0000_0000,
                     64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000};
        // reset key, both directions
        foreach (patterns[i])
        begin
            send_block(OP_ENCRYPT, patterns[i]);
            send_block(OP_DECRYPT, patterns[i]);
        end
        // decrypting a ciphertext must give back the plaintext
        send_block(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF);
        send_block(OP_DECRYPT, last_cipher);
        drain();
    endtask

    task automatic test_key_extremes();
        logic [KEY_W-1:0] keys[4];
        keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                 {$urandom, $urandom}};
        foreach (keys[i])
        begin
            write_key(keys[i]);
            send_block(OP_ENCRYPT, 64'h0);
            send_block(OP_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
            repeat (3)
            begin
                send_block(OP_ENCRYPT, rand_block());
                send_block(OP_DECRYPT, last_cipher);
            end
        end
        drain();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
        write_key({$urandom, $urandom});
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(3) == 0)
                send_block(OP_DECRYPT, last_cipher);
            else
                send_block(logic'($urandom_range(1)), rand_block());
            // mid-phase burst with no gaps
            if (n == count / 2)
                sender_idle_pct = 0;
            if (n == count / 2 + 40)
                sender_idle_pct = idle_pct;
        end
        drain();
    endtask

    initial
    begin
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = OP_ENCRYPT;
        m_tready           = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        rst_n              = 1'b0;
        key_shadow         = KEY_RESET;
        last_cipher        = '0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_patterns();
        test_key_extremes();
        test_random_traffic(0, 0, 450);
        test_random_traffic(74, 0, 450);
        test_random_traffic(0, 74, 450);
        test_random_traffic(16, 16, 450);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[%0t] timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ feistel_two_branch_cipher.f @@
rtl/ftbc_pkg.sv
rtl/ftbc_round_cell.sv
rtl/feistel_two_branch_cipher.sv
tb/testbench.sv
